@@ rtl/core/kpet_pkg.sv @@
package kpet_pkg;

    // Field widths fixed by the item format.
    localparam int KIND_W = 4;
    localparam int ID_W   = 56;
    localparam int KEY_W  = KIND_W + ID_W;
    localparam int TIME_W = 32;
    localparam int PEN_W  = 16;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ADD       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ONE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic              zero_pen;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] expiry;
    } t_cmd;

    // Result of one item.
    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic [STAT_W-1:0] status;
    } t_res;

endpackage

@@ rtl/core/kpet_fifo.sv @@
module kpet_fifo #(
    parameter int W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    // Two-entry queue: enough to decouple producer and consumer by one transfer.
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_do_push;
    logic         w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wp <= ~r_wp;
            end
            if (w_do_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_do_push && w_do_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/core/kpet_front.sv @@
module kpet_front
    import kpet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [KIND_W-1:0] i_id_kind,
    input  logic [ID_W-1:0]   i_cell_id,
    input  logic [TIME_W-1:0] i_now,
    input  logic [PEN_W-1:0]  i_penalty_seconds,
    input  logic              i_cmd_pop,
    output t_cmd              o_cmd,
    output logic              o_cmd_valid
);

    t_cmd w_cmd;
    logic w_empty;

    // Build the key, the new expiry (modulo 2^32) and flag a zero penalty.
    always_comb begin
        w_cmd          = '0;
        w_cmd.act      = i_action;
        w_cmd.zero_pen = (i_penalty_seconds == '0);
        w_cmd.key      = {i_id_kind, i_cell_id};
        w_cmd.now      = i_now;
        w_cmd.expiry   = i_now + {{(TIME_W-PEN_W){1'b0}}, i_penalty_seconds};
    end

    // Command queue between front and back.
    kpet_fifo #(
        .W($bits(t_cmd))
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (w_empty)
    );

    assign o_cmd_valid = !w_empty;

endmodule

@@ rtl/core/kpet_back.sv @@
module kpet_back
    import kpet_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    t_cmd                    r_cmd;
    logic [CW-1:0]           r_idx;
    logic                    r_pv;
    logic [AW-1:0]           r_pidx;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]        mem_key [TABLE_ENTRIES];
    logic [TIME_W-1:0]       mem_exp [TABLE_ENTRIES];
    logic [KEY_W-1:0]        r_rkey;
    logic [TIME_W-1:0]       r_rexp;
    logic                    r_mfound;
    logic [AW-1:0]           r_midx;
    logic [TIME_W-1:0]       r_mexp;
    logic                    r_ffound;
    logic [AW-1:0]           r_fidx;
    logic [TIME_W-1:0]       r_best;

    logic                    w_start;
    logic                    w_issue;
    logic                    w_hit;
    logic                    w_live;
    logic                    w_slot_v;
    logic [TIME_W-1:0]       w_left;
    logic                    w_is_add;
    logic                    w_wr;
    logic [AW-1:0]           w_waddr;

    assign w_start  = (r_state == S_IDLE) && i_cmd_valid && !i_res_full;
    assign w_issue  = (r_state == S_SCAN) && (r_idx != LAST_CNT);
    assign w_is_add = (r_cmd.act == ACT_ADD) && !r_cmd.zero_pen;

    // Compare the entry read in the previous cycle with the command.
    assign w_slot_v = r_valid[r_pidx];
    assign w_hit    = w_slot_v && (r_rkey == r_cmd.key);
    assign w_live   = r_cmd.now < r_rexp;
    assign w_left   = r_rexp - r_cmd.now;

    // Write on an add: raise the matching entry, or fill a free slot.
    always_comb begin
        w_wr    = 1'b0;
        w_waddr = r_fidx;
        if ((r_state == S_FIN) && w_is_add) begin
            if (r_mfound) begin
                w_wr    = (r_mexp < r_cmd.expiry);
                w_waddr = r_midx;
            end else if (r_ffound) begin
                w_wr    = 1'b1;
                w_waddr = r_fidx;
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    if ((i_cmd.act == ACT_CLEAR_ALL) ||
                        ((i_cmd.act == ACT_ADD) && i_cmd.zero_pen)) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if ((r_idx == LAST_CNT) && !r_pv) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_pv <= 1'b0;
            end else begin
                r_pv <= w_issue;
            end
        end
    end

    // Scan bookkeeping: address counter, first match, first free slot, best time.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cmd    <= i_cmd;
            r_idx    <= '0;
            r_mfound <= 1'b0;
            r_ffound <= 1'b0;
            r_best   <= '0;
        end else begin
            if (w_issue) begin
                r_idx  <= r_idx + CW'(1);
                r_pidx <= r_idx[AW-1:0];
            end
            if ((r_state == S_SCAN) && r_pv) begin
                if (w_hit && !r_mfound) begin
                    r_mfound <= 1'b1;
                    r_midx   <= r_pidx;
                    r_mexp   <= r_rexp;
                end
                if ((!w_slot_v || !w_live) && !r_ffound) begin
                    r_ffound <= 1'b1;
                    r_fidx   <= r_pidx;
                end
                if ((r_cmd.act == ACT_QUERY) && w_hit && w_live && (w_left > r_best)) begin
                    r_best <= w_left;
                end
            end
        end
    end

    // Valid bits live in flip-flops and clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_start && (i_cmd.act == ACT_CLEAR_ALL)) begin
                r_valid <= '0;
            end
            if ((r_state == S_SCAN) && r_pv && w_hit && (r_cmd.act == ACT_CLEAR_ONE)) begin
                r_valid[r_pidx] <= 1'b0;
            end
            if (w_wr) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    // Key and expiry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_key[w_waddr] <= r_cmd.key;
            mem_exp[w_waddr] <= r_cmd.expiry;
        end
        if (w_issue) begin
            r_rkey <= mem_key[r_idx[AW-1:0]];
            r_rexp <= mem_exp[r_idx[AW-1:0]];
        end
    end

    // Result of the finished command.
    always_comb begin
        o_res           = '0;
        o_res.status    = ST_DONE;
        o_res.remaining = '0;
        case (r_cmd.act)
            ACT_ADD: begin
                if (r_cmd.zero_pen) begin
                    o_res.status = ST_ZERO;
                end else if (!r_mfound && !r_ffound) begin
                    o_res.status = ST_FULL;
                end
            end
            ACT_QUERY: begin
                o_res.remaining = r_best;
            end
            default: begin
                o_res.status = ST_DONE;
            end
        endcase
    end

    assign o_res_push = (r_state == S_FIN);
    assign o_cmd_pop  = w_start;

endmodule

@@ rtl/core/keyed_penalty_expiry_table_top.sv @@
// Keyed penalty expiry table.
// Input channel: an item (action, id_kind, cell_id, now, penalty_seconds) is
// transferred at a clock edge with push high and full low. Result channel: while
// empty is low the oldest result (remaining, status) is on the ports; it is
// transferred at an edge with pop high.
// Each item yields exactly one result, in order.
// Execution: a query, clear-one or non-zero add scans the table one entry per cycle
// through the key/expiry memory read port, and items are executed one at a time:
// the executor takes the next command only once the last one has finished. A
// zero-penalty add or a clear-all skips the scan.
// A two-entry command queue after the classifier and a two-entry result queue
// let the input side keep transferring while the receiver stalls; when the
// result queue is full the executor holds the next command and full rises
// once the command queue fills.
// Reset (synchronous, active low) empties both queues and marks all slots free;
// there is no clearing pass and the block takes items in the first cycle after.
module keyed_penalty_expiry_table_top
    import kpet_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [KIND_W-1:0] i_id_kind,
    input  logic [ID_W-1:0]   i_cell_id,
    input  logic [TIME_W-1:0] i_now,
    input  logic [PEN_W-1:0]  i_penalty_seconds,
    output logic              empty,
    input  logic              pop,
    output logic [TIME_W-1:0] o_remaining,
    output logic [STAT_W-1:0] o_status
);

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;
    logic w_res_full;
    logic w_res_push;
    t_res w_res;
    t_res w_res_out;

    // Front: classify and queue commands.
    kpet_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_action          (i_action),
        .i_id_kind         (i_id_kind),
        .i_cell_id         (i_cell_id),
        .i_now             (i_now),
        .i_penalty_seconds (i_penalty_seconds),
        .i_cmd_pop         (w_cmd_pop),
        .o_cmd             (w_cmd),
        .o_cmd_valid       (w_cmd_valid)
    );

    // Back: table scan and update.
    kpet_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // Result queue in front of the receiver.
    kpet_fifo #(
        .W($bits(t_res))
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_remaining = w_res_out.remaining;
    assign o_status    = w_res_out.status;

endmodule

@@ rtl/core/kpet_chk.sv @@
module kpet_chk
    import kpet_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [TIME_W-1:0] o_remaining,
    input logic [STAT_W-1:0] o_status
);

    // Reset leaves both sides of the block empty and ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // Only the three defined status codes are ever shown.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == ST_DONE || o_status == ST_FULL || o_status == ST_ZERO))
        else $error("undefined status code");

    // A time remaining is only reported with a done status.
    a_remaining_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_DONE) |-> (o_remaining == '0))
        else $error("remaining time with a failed add");

    // A result not taken stays on the ports unchanged.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_remaining) && $stable(o_status)))
        else $error("result changed before transfer");

endmodule

bind keyed_penalty_expiry_table_top kpet_chk u_kpet_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_remaining (o_remaining),
    .o_status    (o_status)
);
